>>> rtl/core/brf_pkg.sv
// Shared types and codes for the byte ring FIFO with overwrite.
// Used by brf_front, brf_back and the top level byte_ring_fifo_overwrite.
package brf_pkg;

    // request codes as they arrive on s_tuser
    localparam logic [2:0] REQ_PUT       = 3'd0;
    localparam logic [2:0] REQ_POP_ONE   = 3'd1;
    localparam logic [2:0] REQ_POP_COUNT = 3'd2;
    localparam logic [2:0] REQ_POP_UNTIL = 3'd3;
    localparam logic [2:0] REQ_FLUSH     = 3'd4;

    // classified request kinds carried through the request queue
    typedef logic [2:0] req_kind_t;
    localparam req_kind_t KIND_NOP       = 3'd0;
    localparam req_kind_t KIND_PUT       = 3'd1;
    localparam req_kind_t KIND_POP_ONE   = 3'd2;
    localparam req_kind_t KIND_POP_COUNT = 3'd3;
    localparam req_kind_t KIND_POP_UNTIL = 3'd4;
    localparam req_kind_t KIND_FLUSH     = 3'd5;

    localparam int CNT_W = 7;   // fill level, ring length, pop count
    localparam int POS_W = 6;   // slot positions on the ports
    localparam int OVF_W = 32;  // overflow counter

    typedef struct packed {
        req_kind_t          kind;
        logic [7:0]         data;
        logic [CNT_W-1:0]   count;
        logic [POS_W-1:0]   stop;
    } req_t;

    typedef struct packed {
        logic               byte_valid;
        logic               success;
        logic               last;
        logic [CNT_W-1:0]   fill_level;
        logic [CNT_W-1:0]   free_slots;
        logic [POS_W-1:0]   write_position;
        logic [CNT_W-1:0]   high_water;
        logic [OVF_W-1:0]   overflow_total;
        logic               is_full;
        logic               is_empty;
    } res_t;

endpackage

>>> rtl/core/brf_front.sv
// Request front end: classifies incoming beats and holds them in a
// two-entry queue for the back end. Depends on brf_pkg.
module brf_front
    import brf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [2:0]   in_req_type,
    input  logic [7:0]   in_data,
    input  logic [6:0]   in_count,
    input  logic [5:0]   in_stop,
    output logic         req_valid,
    input  logic         req_ready,
    output req_t         req
);

    req_t        q_mem [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  cnt_reg;
    logic [1:0]  cnt_next;
    logic        push;
    logic        pop;
    req_t        entry;

    always_comb
    begin
        entry.data  = in_data;
        entry.count = in_count;
        entry.stop  = in_stop;
        case (in_req_type)
            REQ_PUT:       entry.kind = KIND_PUT;
            REQ_POP_ONE:   entry.kind = KIND_POP_ONE;
            REQ_POP_COUNT: entry.kind = KIND_POP_COUNT;
            REQ_POP_UNTIL: entry.kind = KIND_POP_UNTIL;
            REQ_FLUSH:     entry.kind = KIND_FLUSH;
            default:       entry.kind = KIND_NOP;
        endcase
    end

    assign in_ready  = (cnt_reg != 2'd2);
    assign req_valid = (cnt_reg != 2'd0);
    assign req       = q_mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = req_valid && req_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= entry;
        end
    end

endmodule

>>> rtl/core/brf_back.sv
// Execution back end: ring state, slot memory, multi-byte pop sequencer
// and the result register. Depends on brf_pkg.
module brf_back
    import brf_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [CNT_W-1:0]   cfg_data,
    input  logic               req_valid,
    output logic               req_ready,
    input  req_t               req,
    output logic               res_valid,
    input  logic               res_ready,
    output res_t               res,
    output logic [7:0]         res_byte
);

    localparam int PTR_W = $clog2(DEPTH);

    logic [7:0]        mem [DEPTH];
    logic [7:0]        rd_data_reg;

    logic [CNT_W-1:0]  ring_len_reg;
    logic [PTR_W-1:0]  rd_pos_reg,  rd_pos_next;
    logic [PTR_W-1:0]  wr_pos_reg,  wr_pos_next;
    logic [CNT_W-1:0]  held_reg,    held_next;
    logic [CNT_W-1:0]  peak_reg,    peak_next;
    logic [OVF_W-1:0]  ovf_reg,     ovf_next;
    logic              run_reg,     run_next;
    logic              until_reg,   until_next;
    logic [CNT_W-1:0]  left_reg,    left_next;
    logic [POS_W-1:0]  stop_reg,    stop_next;
    logic              out_valid_reg;
    res_t              res_reg,     res_next;

    logic              out_free;
    logic              fire;
    logic              take_req;
    logic              do_pop;
    logic              mem_we;
    logic [PTR_W-1:0]  rp_adv;
    logic [PTR_W-1:0]  wp_adv;
    logic [CNT_W-1:0]  cfg_len;
    logic              bv, ok, lst;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p,
                                                    input logic [CNT_W-1:0] len);
        logic [CNT_W-1:0] n;
        n = CNT_W'(p) + CNT_W'(1);
        return (n >= len) ? '0 : n[PTR_W-1:0];
    endfunction

    assign out_free  = !out_valid_reg || res_ready;
    assign fire      = out_free && (run_reg || req_valid);
    assign take_req  = out_free && !run_reg && req_valid;
    assign req_ready = take_req;
    assign rp_adv    = next_slot(rd_pos_reg, ring_len_reg);
    assign wp_adv    = next_slot(wr_pos_reg, ring_len_reg);

    always_comb
    begin
        cfg_len = cfg_data;
        if (cfg_data == '0)
        begin
            cfg_len = CNT_W'(1);
        end
        else if (cfg_data > CNT_W'(DEPTH))
        begin
            cfg_len = CNT_W'(DEPTH);
        end
    end

    // one result per fire: either the next byte of a run or a new request
    always_comb
    begin
        rd_pos_next = rd_pos_reg;
        wr_pos_next = wr_pos_reg;
        held_next   = held_reg;
        peak_next   = peak_reg;
        ovf_next    = ovf_reg;
        run_next    = run_reg;
        until_next  = until_reg;
        left_next   = left_reg;
        stop_next   = stop_reg;
        do_pop      = 1'b0;
        mem_we      = 1'b0;
        bv          = 1'b0;
        ok          = 1'b1;
        lst         = 1'b1;

        if (run_reg)
        begin
            do_pop = 1'b1;
            if (until_reg)
            begin
                lst = (POS_W'(rp_adv) == stop_reg) ||
                      (held_reg == CNT_W'(1));
            end
            else
            begin
                lst = (left_reg == CNT_W'(1));
            end
            left_next = left_reg - CNT_W'(1);
            run_next  = !lst;
        end
        else if (take_req)
        begin
            case (req.kind)
                KIND_PUT:
                begin
                    mem_we      = 1'b1;
                    wr_pos_next = wp_adv;
                    if (held_reg < ring_len_reg)
                    begin
                        held_next = held_reg + CNT_W'(1);
                        if (held_next > peak_reg)
                        begin
                            peak_next = held_next;
                        end
                    end
                    else
                    begin
                        rd_pos_next = rp_adv;
                        if (ovf_reg != '1)
                        begin
                            ovf_next = ovf_reg + OVF_W'(1);
                        end
                    end
                end
                KIND_POP_ONE:
                begin
                    if (held_reg == '0)
                    begin
                        ok = 1'b0;
                    end
                    else
                    begin
                        do_pop = 1'b1;
                    end
                end
                KIND_POP_COUNT:
                begin
                    if (req.count > held_reg)
                    begin
                        ok = 1'b0;
                    end
                    else if (req.count != '0)
                    begin
                        do_pop     = 1'b1;
                        lst        = (req.count == CNT_W'(1));
                        run_next   = !lst;
                        until_next = 1'b0;
                        left_next  = req.count - CNT_W'(1);
                    end
                end
                KIND_POP_UNTIL:
                begin
                    if (held_reg == '0)
                    begin
                        ok = 1'b0;
                    end
                    else
                    begin
                        do_pop     = 1'b1;
                        lst        = (POS_W'(rp_adv) == req.stop) ||
                                     (held_reg == CNT_W'(1));
                        run_next   = !lst;
                        until_next = 1'b1;
                        stop_next  = req.stop;
                    end
                end
                KIND_FLUSH:
                begin
                    rd_pos_next = '0;
                    wr_pos_next = '0;
                    held_next   = '0;
                    peak_next   = '0;
                    ovf_next    = '0;
                end
                default:
                begin
                end
            endcase
        end

        if (do_pop)
        begin
            bv          = 1'b1;
            rd_pos_next = rp_adv;
            held_next   = held_reg - CNT_W'(1);
        end

        res_next.byte_valid     = bv;
        res_next.success        = ok;
        res_next.last           = lst;
        res_next.fill_level     = held_next;
        res_next.free_slots     = ring_len_reg - held_next;
        res_next.write_position = POS_W'(wr_pos_next);
        res_next.high_water     = peak_next;
        res_next.overflow_total = ovf_next;
        res_next.is_full        = (held_next == ring_len_reg);
        res_next.is_empty       = (held_next == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_len_reg  <= CNT_W'(DEPTH);
            rd_pos_reg    <= '0;
            wr_pos_reg    <= '0;
            held_reg      <= '0;
            peak_reg      <= '0;
            ovf_reg       <= '0;
            run_reg       <= 1'b0;
            until_reg     <= 1'b0;
            left_reg      <= '0;
            stop_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                ring_len_reg <= cfg_len;
                rd_pos_reg   <= '0;
                wr_pos_reg   <= '0;
                held_reg     <= '0;
                peak_reg     <= '0;
                ovf_reg      <= '0;
                run_reg      <= 1'b0;
            end
            else if (fire)
            begin
                rd_pos_reg <= rd_pos_next;
                wr_pos_reg <= wr_pos_next;
                held_reg   <= held_next;
                peak_reg   <= peak_next;
                ovf_reg    <= ovf_next;
                run_reg    <= run_next;
                until_reg  <= until_next;
                left_reg   <= left_next;
                stop_reg   <= stop_next;
            end

            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= res_next;
        end
    end

    // slot memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (fire && mem_we)
        begin
            mem[wp_adv] <= req.data;
        end
        if (fire && do_pop)
        begin
            rd_data_reg <= mem[rp_adv];
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = res_reg;
    assign res_byte  = res_reg.byte_valid ? rd_data_reg : 8'd0;

    a_held_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= ring_len_reg)
        else $error("fill level above ring length");

    a_peak_covers_held: assert property (@(posedge clk) disable iff (!rst_n)
        peak_reg >= held_reg)
        else $error("high-water mark below fill level");

    a_run_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg |-> (held_reg != '0))
        else $error("pop run active on empty ring");

    a_byte_implies_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.byte_valid) |-> res_reg.success)
        else $error("popped byte flagged as failed");

    a_run_holds_queue: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg |-> !req_ready)
        else $error("new request taken during a pop run");

endmodule

>>> rtl/core/byte_ring_fifo_overwrite.sv
// Top level of the byte ring FIFO with overwrite of the oldest byte.
// Instantiates brf_front and brf_back; types and codes from brf_pkg.
//
// Usage:
//   s_* carries requests: s_tuser is the request code (put, pop one, pop
//   count, pop until position, flush); s_tdata carries the byte and operands.
//   m_* carries results: one beat per request, except pop count and pop
//   until, which give one beat per popped byte; m_tlast marks the final beat
//   of a request. m_tuser flags that the byte field holds a popped byte.
//   cfg_we/cfg_data set the ring length (0 reads as 1, above DEPTH as DEPTH)
//   and flush the ring; write it only while no request is in flight.
// Path: an accepted request beat passes the request queue, then the result
//   register, before its first result beat appears on m_*.
// Throughput: one result beat per cycle while m_tready does not stall, set by
//   the single execution unit and its one-read, one-write slot memory; a
//   multi-byte pop holds the unit until its last byte is out.
// Reset: empty ring, ring length DEPTH, all counters zero; slot contents
//   are undefined until written. No clearing pass is needed.
// Stall: a stalled m_tready holds the result register; the two-entry request
//   queue keeps accepting until full, then s_tready drops.
module byte_ring_fifo_overwrite
    import brf_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [6:0]   cfg_data,      // ring_length
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [23:0]  s_tdata,       // in_byte[7:0], pop_count[14:8],
                                        // stop_position[20:15], zero pad
    input  logic [2:0]   s_tuser,       // req_type
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [71:0]  m_tdata,       // out_byte[7:0], success[8],
                                        // fill_level[15:9], free_slots[22:16],
                                        // write_position[28:23],
                                        // high_water[35:29],
                                        // overflow_total[67:36], is_full[68],
                                        // is_empty[69], zero pad
    output logic         m_tuser,       // byte_valid
    output logic         m_tlast        // last
);

    logic        req_valid;
    logic        req_ready;
    req_t        req;
    res_t        res;
    logic [7:0]  res_byte;

    brf_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_req_type (s_tuser),
        .in_data     (s_tdata[7:0]),
        .in_count    (s_tdata[14:8]),
        .in_stop     (s_tdata[20:15]),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req)
    );

    brf_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res),
        .res_byte  (res_byte)
    );

    // result beat packing, highest field first
    assign m_tdata = {2'b00,
                      res.is_empty,
                      res.is_full,
                      res.overflow_total,
                      res.high_water,
                      res.write_position,
                      res.free_slots,
                      res.fill_level,
                      res.success,
                      res_byte};
    assign m_tuser = res.byte_valid;
    assign m_tlast = res.last;

endmodule

>>> verif/testbench.sv
// Self-checking testbench for byte_ring_fifo_overwrite (ring FIFO, overwrite on full).
// Depends on brf_pkg for request codes and the result status type; needs only the RTL.
// Directed table first, then random phases at several ring lengths, all checked by a predictor.
module testbench
    import brf_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_DEPTH = 64;

    // request codes the block ignores; each still answers with one status beat
    localparam logic [2:0] REQ_UNKNOWN_LO = 3'd5;
    localparam logic [2:0] REQ_UNKNOWN_HI = 3'd7;

    localparam int STALL_PCT      = 6;     // idle chance per cycle, each side
    localparam int WATCHDOG_LIMIT = 5000;  // cycles with no beat on either side

    // one result beat as seen on the master side
    typedef struct packed {
        logic [7:0] out_byte;
        res_t       st;
    } ring_beat_t;

    // a row of the directed table; pin_* overrides the predicted beat where the
    // answer is obvious (after reset, extremes, failed pops)
    typedef struct packed {
        logic       is_cfg;
        logic [6:0] cfg_val;
        logic [2:0] kind;
        logic [7:0] in_byte;
        logic [6:0] count;
        logic [5:0] stop;
        logic       pinned;
        logic       pin_valid;
        logic       pin_ok;
        logic [7:0] pin_byte;
        logic [6:0] pin_fill;
    } dir_row_t;

    localparam int DIR_ROWS_N = 22;
    localparam dir_row_t DIR_ROWS [DIR_ROWS_N] = '{
        // empty ring straight after reset: failed pops, zero-count pop
        '{1'b0, 7'd0,   REQ_POP_ONE,    8'h00, 7'd0,   6'd0,  1'b1, 1'b0, 1'b0, 8'h00, 7'd0},
        '{1'b0, 7'd0,   REQ_POP_UNTIL,  8'h00, 7'd0,   6'd0,  1'b1, 1'b0, 1'b0, 8'h00, 7'd0},
        '{1'b0, 7'd0,   REQ_POP_COUNT,  8'h00, 7'd0,   6'd0,  1'b1, 1'b0, 1'b1, 8'h00, 7'd0},
        '{1'b0, 7'd0,   REQ_POP_COUNT,  8'h00, 7'd1,   6'd0,  1'b1, 1'b0, 1'b0, 8'h00, 7'd0},
        // byte extremes in, count too large, then a good single pop
        '{1'b0, 7'd0,   REQ_PUT,        8'h00, 7'd0,   6'd0,  1'b1, 1'b0, 1'b1, 8'h00, 7'd1},
        '{1'b0, 7'd0,   REQ_PUT,        8'hFF, 7'd127, 6'd63, 1'b1, 1'b0, 1'b1, 8'h00, 7'd2},
        '{1'b0, 7'd0,   REQ_POP_COUNT,  8'h00, 7'd64,  6'd0,  1'b1, 1'b0, 1'b0, 8'h00, 7'd2},
        '{1'b0, 7'd0,   REQ_POP_COUNT,  8'hFF, 7'd127, 6'd63, 1'b1, 1'b0, 1'b0, 8'h00, 7'd2},
        '{1'b0, 7'd0,   REQ_POP_ONE,    8'h00, 7'd0,   6'd0,  1'b1, 1'b1, 1'b1, 8'h00, 7'd1},
        // unknown codes are ignored, then a flush
        '{1'b0, 7'd0,   REQ_UNKNOWN_LO, 8'hFF, 7'd127, 6'd63, 1'b1, 1'b0, 1'b1, 8'h00, 7'd1},
        '{1'b0, 7'd0,   REQ_UNKNOWN_HI, 8'h00, 7'd0,   6'd0,  1'b1, 1'b0, 1'b1, 8'h00, 7'd1},
        '{1'b0, 7'd0,   REQ_FLUSH,      8'h00, 7'd0,   6'd0,  1'b1, 1'b0, 1'b1, 8'h00, 7'd0},
        // ring of three: fill, overwrite twice, pop until a slot, pop the rest
        '{1'b1, 7'd3,   REQ_PUT,        8'h00, 7'd0,   6'd0,  1'b0, 1'b0, 1'b0, 8'h00, 7'd0},
        '{1'b0, 7'd0,   REQ_PUT,        8'hA5, 7'd0,   6'd0,  1'b0, 1'b0, 1'b0, 8'h00, 7'd0},
        '{1'b0, 7'd0,   REQ_PUT,        8'h5A, 7'd0,   6'd0,  1'b0, 1'b0, 1'b0, 8'h00, 7'd0},
        '{1'b0, 7'd0,   REQ_PUT,        8'h3C, 7'd0,   6'd0,  1'b0, 1'b0, 1'b0, 8'h00, 7'd0},
        '{1'b0, 7'd0,   REQ_PUT,        8'hC3, 7'd0,   6'd0,  1'b0, 1'b0, 1'b0, 8'h00, 7'd0},
        '{1'b0, 7'd0,   REQ_PUT,        8'h81, 7'd0,   6'd0,  1'b0, 1'b0, 1'b0, 8'h00, 7'd0},
        '{1'b0, 7'd0,   REQ_POP_UNTIL,  8'h00, 7'd0,   6'd1,  1'b0, 1'b0, 1'b0, 8'h00, 7'd0},
        '{1'b0, 7'd0,   REQ_POP_COUNT,  8'h00, 7'd1,   6'd0,  1'b0, 1'b0, 1'b0, 8'h00, 7'd0},
        // zero length reads as one slot; one put into it
        '{1'b1, 7'd0,   REQ_PUT,        8'h00, 7'd0,   6'd0,  1'b0, 1'b0, 1'b0, 8'h00, 7'd0},
        '{1'b0, 7'd0,   REQ_PUT,        8'h11, 7'd0,   6'd0,  1'b0, 1'b0, 1'b0, 8'h00, 7'd0}
    };

    // ring lengths written per random phase; the entry marked below is replaced
    // by a random register value
    localparam int PHASES = 5;
    localparam logic [6:0] PHASE_LEN [PHASES] = '{7'd5, 7'd127, 7'd1, 7'd0, 7'd2};
    localparam int RANDOM_LEN_PHASE = 3;
    localparam int CALM_PHASE       = 1;  // no idling on either side
    localparam int PAUSE_PHASE      = 2;  // sender waits for all results mid-phase

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [6:0]  cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;   // in_byte[7:0], pop_count[14:8], stop_position[20:15]
    logic [2:0]  s_tuser = '0;   // req_type
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;        // out_byte, success, fill_level, free_slots,
                                 // write_position, high_water, overflow_total,
                                 // is_full, is_empty (low to high)
    logic        m_tuser;        // byte_valid
    logic        m_tlast;        // last

    bit calm = 1'b0;
    int mismatches = 0;
    int stuck_cycles = 0;

    // predicted result beats, oldest first
    ring_beat_t pending_results[$];

    // shadow of the ring: contents, positions, counters, ring length
    logic [7:0]  slot_mem [RING_DEPTH];
    logic [5:0]  rd_slot = '0;     // slot read last
    logic [5:0]  wr_slot = '0;     // slot written last
    logic [6:0]  held = '0;
    logic [6:0]  peak = '0;
    logic [31:0] ovf_cnt = '0;
    logic [6:0]  ring_len = 7'(RING_DEPTH);

    byte_ring_fifo_overwrite #(.DEPTH(RING_DEPTH)) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic [5:0] next_slot_of(input logic [5:0] p);
        return ({1'b0, p} + 7'd1 >= ring_len) ? 6'd0 : p + 6'd1;
    endfunction

    function automatic void clear_ring_counts();
        rd_slot = '0;
        wr_slot = '0;
        held    = '0;
        peak    = '0;
        ovf_cnt = '0;
    endfunction

    // status fields always reflect the ring after this beat's byte left it
    function automatic void push_beat(input logic [7:0] b, input logic bv, input logic ok,
                                      input logic fin);
        ring_beat_t e;
        e.out_byte          = b;
        e.st.byte_valid     = bv;
        e.st.success        = ok;
        e.st.last           = fin;
        e.st.fill_level     = held;
        e.st.free_slots     = ring_len - held;
        e.st.write_position = wr_slot;
        e.st.high_water     = peak;
        e.st.overflow_total = ovf_cnt;
        e.st.is_full        = (held == ring_len);
        e.st.is_empty       = (held == 0);
        pending_results.push_back(e);
    endfunction

    function automatic logic [7:0] take_byte();
        rd_slot = next_slot_of(rd_slot);
        held    = held - 7'd1;
        return slot_mem[rd_slot];
    endfunction

    function automatic void predict_ring_results(input logic [2:0] kind, input logic [7:0] b,
                                                 input logic [6:0] cnt, input logic [5:0] stop);
        int          n;
        logic [7:0]  v;
        logic        done;
        case (kind)
            REQ_PUT:
            begin
                wr_slot = next_slot_of(wr_slot);
                slot_mem[wr_slot] = b;
                if (held < ring_len)
                begin
                    held = held + 7'd1;
                    if (held > peak)
                        peak = held;
                end
                else
                begin
                    // full: the oldest byte is dropped along with the read side
                    rd_slot = next_slot_of(rd_slot);
                    if (ovf_cnt != '1)
                        ovf_cnt = ovf_cnt + 32'd1;
                end
                push_beat(8'h00, 1'b0, 1'b1, 1'b1);
            end
            REQ_POP_ONE:
            begin
                if (held == 0)
                    push_beat(8'h00, 1'b0, 1'b0, 1'b1);
                else
                begin
                    v = take_byte();
                    push_beat(v, 1'b1, 1'b1, 1'b1);
                end
            end
            REQ_POP_COUNT:
            begin
                if (cnt > held)
                    push_beat(8'h00, 1'b0, 1'b0, 1'b1);
                else if (cnt == 0)
                    push_beat(8'h00, 1'b0, 1'b1, 1'b1);
                else
                    for (n = int'(cnt); n > 0; n--)
                    begin
                        v = take_byte();
                        push_beat(v, 1'b1, 1'b1, n == 1);
                    end
            end
            REQ_POP_UNTIL:
            begin
                if (held == 0)
                    push_beat(8'h00, 1'b0, 1'b0, 1'b1);
                else
                begin
                    n = 0;
                    do
                    begin
                        v = take_byte();
                        done = (rd_slot == stop) || (held == 0) || (n + 1 >= RING_DEPTH);
                        push_beat(v, 1'b1, 1'b1, done);
                        n++;
                    end
                    while (!done);
                end
            end
            REQ_FLUSH:
            begin
                clear_ring_counts();
                push_beat(8'h00, 1'b0, 1'b1, 1'b1);
            end
            default:
                push_beat(8'h00, 1'b0, 1'b1, 1'b1);
        endcase
    endfunction

    // ---------------------------------------------------------------- sender side

    // one request beat; valid stays high into the next request unless we idle
    task automatic send_req(input logic [2:0] kind, input logic [7:0] b,
                            input logic [6:0] cnt, input logic [5:0] stop);
        while (!calm && $urandom_range(99) < STALL_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {3'b000, stop, cnt, b};
        do
            @(posedge clk);
        while (!s_tready);
        predict_ring_results(kind, b, cnt, stop);
    endtask

    // stop sending, wait for every predicted beat, then cover the pipeline latency
    task automatic wait_ring_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // register write only with the block idle; it also flushes the ring
    task automatic set_ring_length(input logic [6:0] v);
        wait_ring_drained();
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        if (v == 0)
            ring_len = 7'd1;
        else if (v > RING_DEPTH)
            ring_len = 7'(RING_DEPTH);
        else
            ring_len = v;
        clear_ring_counts();
    endtask

    // mostly legal pops (count within the fill, stop inside the ring), some noise
    task automatic send_random_req();
        int unsigned roll;
        logic [2:0]  kind;
        logic [6:0]  cnt;
        logic [5:0]  stop;
        roll = $urandom_range(99);
        cnt  = 7'($urandom_range(127));
        stop = 6'($urandom());
        if (roll < 45)
            kind = REQ_PUT;
        else if (roll < 60)
            kind = REQ_POP_ONE;
        else if (roll < 78)
        begin
            kind = REQ_POP_COUNT;
            if (roll < 74 && held != 0)
                cnt = 7'($urandom_range(held, 1));
        end
        else if (roll < 93)
        begin
            kind = REQ_POP_UNTIL;
            if (roll < 90)
                stop = 6'($urandom_range(ring_len - 7'd1));
        end
        else if (roll < 97)
            kind = REQ_FLUSH;
        else
            kind = 3'($urandom_range(REQ_UNKNOWN_HI, REQ_UNKNOWN_LO));
        send_req(kind, 8'($urandom()), cnt, stop);
    endtask

    task automatic send_put_burst(input int n);
        repeat (n) send_req(REQ_PUT, 8'($urandom()), 7'($urandom()), 6'($urandom()));
    endtask

    // ---------------------------------------------------------------- receiver side

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    // random back-pressure and in-order compare of every accepted result beat
    always @(posedge clk)
    begin : result_check
        ring_beat_t got;
        ring_beat_t want;
        if (rst_n)
        begin
            m_tready <= calm || ($urandom_range(99) >= STALL_PCT);
            if (m_tvalid && m_tready)
            begin
                got.out_byte          = m_tdata[7:0];
                got.st.byte_valid     = m_tuser;
                got.st.success        = m_tdata[8];
                got.st.last           = m_tlast;
                got.st.fill_level     = m_tdata[15:9];
                got.st.free_slots     = m_tdata[22:16];
                got.st.write_position = m_tdata[28:23];
                got.st.high_water     = m_tdata[35:29];
                got.st.overflow_total = m_tdata[67:36];
                got.st.is_full        = m_tdata[68];
                got.st.is_empty       = m_tdata[69];
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t ns: result beat with nothing expected, expected none, got %h",
                             $time, m_tdata);
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("out_byte", 32'(want.out_byte), 32'(got.out_byte));
                    check_field("byte_valid", 32'(want.st.byte_valid),
                                32'(got.st.byte_valid));
                    check_field("success", 32'(want.st.success), 32'(got.st.success));
                    check_field("last", 32'(want.st.last), 32'(got.st.last));
                    check_field("fill_level", 32'(want.st.fill_level),
                                32'(got.st.fill_level));
                    check_field("free_slots", 32'(want.st.free_slots),
                                32'(got.st.free_slots));
                    check_field("write_position", 32'(want.st.write_position),
                                32'(got.st.write_position));
                    check_field("high_water", 32'(want.st.high_water),
                                32'(got.st.high_water));
                    check_field("overflow_total", want.st.overflow_total,
                                got.st.overflow_total);
                    check_field("is_full", 32'(want.st.is_full), 32'(got.st.is_full));
                    check_field("is_empty", 32'(want.st.is_empty), 32'(got.st.is_empty));
                end
            end
        end
    end

    // watchdog: any beat on either side restarts the count
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stuck_cycles <= 0;
            else
                stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t ns: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------- stimulus

    initial
    begin
        ring_beat_t pin;
        logic [6:0] len;
        int         p;
        int         n;

        // reset held low at start, released away from the rising edge
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table; pinned rows carry a single beat whose key fields are
        // typed in by hand
        for (int i = 0; i < DIR_ROWS_N; i++)
        begin
            if (DIR_ROWS[i].is_cfg)
                set_ring_length(DIR_ROWS[i].cfg_val);
            else
            begin
                send_req(DIR_ROWS[i].kind, DIR_ROWS[i].in_byte, DIR_ROWS[i].count,
                         DIR_ROWS[i].stop);
                if (DIR_ROWS[i].pinned)
                begin
                    pin = pending_results.pop_back();
                    pin.out_byte      = DIR_ROWS[i].pin_byte;
                    pin.st.byte_valid = DIR_ROWS[i].pin_valid;
                    pin.st.success    = DIR_ROWS[i].pin_ok;
                    pin.st.fill_level = DIR_ROWS[i].pin_fill;
                    pending_results.push_back(pin);
                end
            end
        end
        // one-slot ring: overwrite, pop until a stop position past the ring,
        // then a pop on empty
        send_req(REQ_PUT, 8'h22, 7'd0, 6'd0);
        send_req(REQ_POP_UNTIL, 8'h00, 7'd0, 6'd63);
        send_req(REQ_POP_ONE, 8'h00, 7'd0, 6'd0);

        // random phases, each at its own ring length; every phase starts with a
        // burst of puts, and small rings are filled past full so overwrites and
        // the high-water mark get exercised
        for (p = 0; p < PHASES; p++)
        begin
            if (p == RANDOM_LEN_PHASE)
                len = 7'($urandom_range(127));
            else
                len = PHASE_LEN[p];
            set_ring_length(len);
            calm = (p == CALM_PHASE);
            send_put_burst((ring_len <= 16) ? int'(ring_len) + 2 : 12);
            // large rings: drain what was put as one run
            if (ring_len > 16)
                send_req(REQ_POP_COUNT, 8'($urandom()), held, 6'($urandom()));
            for (n = 0; n < 6; n++)
            begin
                if (n == 3)
                begin
                    if (p == PAUSE_PHASE)
                        wait_ring_drained();
                    if (ring_len <= 16)
                        send_put_burst(int'(ring_len) + 1);
                end
                send_random_req();
            end
            calm = 1'b0;
        end

        wait_ring_drained();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> byte_ring_fifo_overwrite.f
rtl/core/brf_pkg.sv
rtl/core/brf_front.sv
rtl/core/brf_back.sv
rtl/core/byte_ring_fifo_overwrite.sv
verif/testbench.sv
